// File: rtl/baoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baoc_pkg: shared types, constants and helpers of the altitude observer
//
// Field widths, register indexes and reset values, the sequencer state type
// and the saturating narrowing helper used by the core.
// ----------------------------------------------------------------------------
package baoc_pkg;

	localparam int GAIN_W  = 24;
	localparam int DT_W    = 24;
	localparam int LIM_W   = 31;
	localparam int WORD_W  = 32;
	localparam int SUM_W   = 44;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int GAIN_SH = 16;
	localparam int STEP_SH = 24;

	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 184;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t REG_GAIN_POSITION = 3'd0;
	localparam cfg_idx_t REG_GAIN_VELOCITY = 3'd1;
	localparam cfg_idx_t REG_GAIN_BIAS     = 3'd2;
	localparam cfg_idx_t REG_BIAS_LIMIT    = 3'd3;
	localparam cfg_idx_t REG_BARO_MAX_AGE  = 3'd4;
	localparam cfg_idx_t REG_DT_MAX        = 3'd5;

	localparam logic [GAIN_W-1:0] RST_GAIN_POSITION = 24'd196608;
	localparam logic [GAIN_W-1:0] RST_GAIN_VELOCITY = 24'd196608;
	localparam logic [GAIN_W-1:0] RST_GAIN_BIAS     = 24'd65536;
	localparam logic [LIM_W-1:0]  RST_BIAS_LIMIT    = 31'd131072;
	localparam logic [WORD_W-1:0] RST_BARO_MAX_AGE  = 32'd200000;
	localparam logic [DT_W-1:0]   RST_DT_MAX        = 24'd167772;

	typedef logic signed [SUM_W-1:0] sum_t;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_PREP  = 11'b000_0000_0010,
		S_ERR   = 11'b000_0000_0100,
		S_GP    = 11'b000_0000_1000,
		S_GV    = 11'b000_0001_0000,
		S_GB    = 11'b000_0010_0000,
		S_ZA    = 11'b000_0100_0000,
		S_VA    = 11'b000_1000_0000,
		S_BA    = 11'b001_0000_0000,
		S_BC    = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	// Saturate a wide signed sum to the signed 32-bit range.
	function automatic logic signed [WORD_W-1:0] sat32(input sum_t v);
		if (!v[SUM_W-1] && (|v[SUM_W-2:WORD_W-1])) begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end else if (v[SUM_W-1] && !(&v[SUM_W-2:WORD_W-1])) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			return v[WORD_W-1:0];
		end
	endfunction

endpackage

// File: rtl/baro_accel_altitude_observer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_accel_altitude_observer_core: barometer and accelerometer altitude
// observer
//
// Each input item is one inertial sample with a Q0.24 time step, a Q16.16
// upward acceleration, a timestamp and an optional barometer altitude with
// its own timestamp. Items with a zero time step or one above dt_max are
// dropped without a result. No result is produced until the first fresh
// barometer reading, which seeds the altitude with speed and bias at zero.
// A fresh reading runs a third-order complementary observer that also tracks
// a clamped accelerometer bias; otherwise speed and altitude are integrated
// from the bias-corrected acceleration. All state is Q16.16 and saturates.
// The core works on one item at a time. With a barometer correction the
// sequencer runs S_PREP, S_ERR, S_GP, S_GV, S_GB, S_ZA, S_VA, S_BA, S_BC and
// S_OUT; otherwise it skips S_GP, S_GV, S_GB and S_BC. The core is ready
// again from the edge that raises the result. Dropped items leave S_PREP
// straight for S_IDLE. The core is built around a single registered
// 33 x 25 bit multiplier that a small sequencer uses for all six products
// in turn. A finished result waits in an output register, and the core takes
// the next item while it waits; it only stalls at its final step if that
// register is still occupied.
// ----------------------------------------------------------------------------
module baro_accel_altitude_observer_core
	import baoc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input items.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [23:0] dt, [55:24] accel_up_in, [87:56] attitude_time_us,
	// [119:88] baro_altitude, [151:120] baro_time_us
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] baro_available
	input  logic                  s_axis_tuser,
	// Result items.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [31:0] altitude, [63:32] vertical_speed, [95:64] accel_up_out,
	// [127:96] accel_bias, [151:128] dt_out, [183:152] time_out_us
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [0] baro_fresh
	output logic                  m_axis_tuser,
	// Configuration writes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [WORD_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [GAIN_W-1:0] gain_position_q;
	logic [GAIN_W-1:0] gain_velocity_q;
	logic [GAIN_W-1:0] gain_bias_q;
	logic [LIM_W-1:0]  bias_limit_q;
	logic [WORD_W-1:0] baro_max_age_q;
	logic [DT_W-1:0]   dt_max_q;

	// Latched input item.
	logic [DT_W-1:0]          dt_q;
	logic signed [WORD_W-1:0] accel_q;
	logic [WORD_W-1:0]        att_time_q;
	logic                     baro_avail_q;
	logic signed [WORD_W-1:0] baro_alt_q;
	logic [WORD_W-1:0]        baro_time_q;

	// Observer state.
	logic                     started_q;
	logic signed [WORD_W-1:0] alt_q;
	logic signed [WORD_W-1:0] speed_q;
	logic signed [WORD_W-1:0] bias_q;

	// Working registers of the sequencer.
	state_t                    state_q;
	logic                      fresh_q;
	logic signed [WORD_W:0]    err_q;
	logic signed [WORD_W-1:0]  az_q;
	logic signed [WORD_W-1:0]  term_z_q;
	logic signed [WORD_W-1:0]  term_v_q;
	logic signed [WORD_W-1:0]  term_b_q;
	logic signed [PROD_W-1:0]  prod_q;

	// Output register.
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_fresh_q;

	logic                         in_accept;
	logic                         dt_ok;
	logic                         fresh;
	logic [WORD_W-1:0]            baro_age;
	logic signed [MUL_A_W-1:0]    mul_a;
	logic signed [MUL_B_W-1:0]    mul_b;
	logic signed [PROD_W-GAIN_SH-1:0] gain_p;
	logic signed [PROD_W-STEP_SH-1:0] step_p;
	logic signed [WORD_W-1:0]     bias_sat;
	logic signed [WORD_W-1:0]     lim_pos;
	logic signed [WORD_W-1:0]     lim_neg;
	logic signed [WORD_W-1:0]     bias_clamped;
	logic                         out_free;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_fresh_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Step checks on the latched item. The barometer age wraps at 32 bits.
	assign baro_age = att_time_q - baro_time_q;
	assign dt_ok    = (dt_q != '0) && (dt_q <= dt_max_q);
	assign fresh    = baro_avail_q && (baro_time_q != '0) && (baro_age < baro_max_age_q);

	// Products come back floored: an arithmetic shift of the signed product.
	assign gain_p = prod_q[PROD_W-1:GAIN_SH];
	assign step_p = prod_q[PROD_W-1:STEP_SH];

	// Bias update with its symmetric clamp.
	assign bias_sat     = sat32(sum_t'(bias_q) + sum_t'(step_p));
	assign lim_pos      = $signed({1'b0, bias_limit_q});
	assign lim_neg      = -lim_pos;
	assign bias_clamped = (bias_sat > lim_pos) ? lim_pos :
	                      (bias_sat < lim_neg) ? lim_neg : bias_sat;

	// Operand selection for the shared multiplier. Gain products take the
	// altitude error; step products take a saturated term and the time step.
	always_comb begin
		mul_a = err_q;
		mul_b = $signed({1'b0, gain_position_q});
		case (state_q)
			S_GP: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, gain_position_q});
			end
			S_GV: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, gain_velocity_q});
			end
			S_GB: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, gain_bias_q});
			end
			S_ZA: begin
				mul_a = fresh_q ? {term_z_q[WORD_W-1], term_z_q}
				                : {speed_q[WORD_W-1], speed_q};
				mul_b = $signed({1'b0, dt_q});
			end
			S_VA: begin
				mul_a = fresh_q ? {term_v_q[WORD_W-1], term_v_q}
				                : {az_q[WORD_W-1], az_q};
				mul_b = $signed({1'b0, dt_q});
			end
			S_BA: begin
				mul_a = {term_b_q[WORD_W-1], term_b_q};
				mul_b = $signed({1'b0, dt_q});
			end
			default: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, gain_position_q});
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_position_q <= RST_GAIN_POSITION;
			gain_velocity_q <= RST_GAIN_VELOCITY;
			gain_bias_q     <= RST_GAIN_BIAS;
			bias_limit_q    <= RST_BIAS_LIMIT;
			baro_max_age_q  <= RST_BARO_MAX_AGE;
			dt_max_q        <= RST_DT_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_POSITION: gain_position_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_VELOCITY: gain_velocity_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_BIAS:     gain_bias_q     <= cfg_data[GAIN_W-1:0];
				REG_BIAS_LIMIT:    bias_limit_q    <= cfg_data[LIM_W-1:0];
				REG_BARO_MAX_AGE:  baro_max_age_q  <= cfg_data;
				REG_DT_MAX:        dt_max_q        <= cfg_data[DT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input item capture.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			dt_q         <= s_axis_tdata[23:0];
			accel_q      <= s_axis_tdata[55:24];
			att_time_q   <= s_axis_tdata[87:56];
			baro_alt_q   <= s_axis_tdata[119:88];
			baro_time_q  <= s_axis_tdata[151:120];
			baro_avail_q <= s_axis_tuser;
		end
	end

	// Working terms of the observer step.
	always_ff @(posedge clk) begin
		case (state_q)
			S_PREP: fresh_q <= fresh;
			S_ERR: begin
				err_q <= $signed({baro_alt_q[WORD_W-1], baro_alt_q})
				       - $signed({alt_q[WORD_W-1], alt_q});
				az_q  <= sat32(sum_t'(accel_q) - sum_t'(bias_q));
			end
			S_GV: term_z_q <= sat32(sum_t'(speed_q) + sum_t'(gain_p));
			S_GB: term_v_q <= sat32(sum_t'(az_q) + sum_t'(gain_p));
			S_ZA: term_b_q <= sat32(sum_t'(0) - sum_t'(gain_p));
			default: begin
			end
		endcase
	end

	// Sequencer and observer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			alt_q     <= '0;
			speed_q   <= '0;
			bias_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (!dt_ok || (!started_q && !fresh)) begin
						state_q <= S_IDLE;
					end else begin
						if (!started_q) begin
							// The first fresh reading seeds the observer.
							started_q <= 1'b1;
							alt_q     <= baro_alt_q;
							speed_q   <= '0;
							bias_q    <= '0;
						end
						state_q <= S_ERR;
					end
				end
				S_ERR: state_q <= fresh_q ? S_GP : S_ZA;
				S_GP:  state_q <= S_GV;
				S_GV:  state_q <= S_GB;
				S_GB:  state_q <= S_ZA;
				S_ZA:  state_q <= S_VA;
				S_VA: begin
					alt_q   <= sat32(sum_t'(alt_q) + sum_t'(step_p));
					state_q <= S_BA;
				end
				S_BA: begin
					speed_q <= sat32(sum_t'(speed_q) + sum_t'(step_p));
					state_q <= fresh_q ? S_BC : S_OUT;
				end
				S_BC: begin
					bias_q  <= bias_clamped;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_data_q  <= {att_time_q, dt_q, bias_q, accel_q, speed_q, alt_q};
			out_fresh_q <= fresh_q;
		end
	end

	// Once seeded, the observer never returns to the unseeded state.
	a_started_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started_q))
		else $error("observer lost its seeded state");

	// A new result only appears from the final step of a seeded observer.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q == S_OUT) && started_q))
		else $error("result item raised outside the output step");

	// The bias update always lands inside the configured clamp.
	a_bias_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BC) |=> ((bias_q <= $signed({1'b0, $past(bias_limit_q)}))
			&& (bias_q >= -$signed({1'b0, $past(bias_limit_q)}))))
		else $error("bias estimate outside its clamp");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the barometer and accelerometer observer
//
// Streams inertial samples, with or without barometer readings, into the core
// and predicts every estimate with an independent bit-exact observer. Result
// items are checked in order, field by field. The run visits several register
// settings including the extremes. Both stream sides idle at random, and the
// result side is held off once for long enough to back the core up.
// ----------------------------------------------------------------------------
import baoc_pkg::*;

typedef struct packed {
	logic [DT_W-1:0]    dt;
	logic signed [31:0] accel;
	logic [31:0]        att_time;
	logic               baro_avail;
	logic signed [31:0] baro_alt;
	logic [31:0]        baro_time;
} imu_sample_t;

typedef struct packed {
	logic signed [31:0] altitude;
	logic signed [31:0] speed;
	logic signed [31:0] accel_echo;
	logic signed [31:0] bias;
	logic               fresh;
	logic [DT_W-1:0]    dt_echo;
	logic [31:0]        time_echo;
} estimate_t;

// Holds a private copy of the observer state and registers, predicts the
// estimate for each accepted sample and checks result items against it.
class altitude_scoreboard;
	logic [23:0]        k_pos;
	logic [23:0]        k_vel;
	logic [23:0]        k_bias;
	logic [30:0]        bias_clamp;
	logic [31:0]        fresh_window;
	logic [23:0]        step_limit;
	bit                 seeded;
	logic signed [31:0] alt_q;
	logic signed [31:0] speed_q;
	logic signed [31:0] bias_q;
	estimate_t          expected_q[$];
	int unsigned        mismatches;

	function new();
		k_pos        = RST_GAIN_POSITION;
		k_vel        = RST_GAIN_VELOCITY;
		k_bias       = RST_GAIN_BIAS;
		bias_clamp   = RST_BIAS_LIMIT;
		fresh_window = RST_BARO_MAX_AGE;
		step_limit   = RST_DT_MAX;
		seeded       = 1'b0;
		alt_q        = '0;
		speed_q      = '0;
		bias_q       = '0;
		mismatches   = 0;
	endfunction

	function void write_reg(cfg_idx_t idx, logic [31:0] data);
		case (idx)
			REG_GAIN_POSITION: k_pos = data[23:0];
			REG_GAIN_VELOCITY: k_vel = data[23:0];
			REG_GAIN_BIAS:     k_bias = data[23:0];
			REG_BIAS_LIMIT:    bias_clamp = data[30:0];
			REG_BARO_MAX_AGE:  fresh_window = data;
			REG_DT_MAX:        step_limit = data[23:0];
			default: ;
		endcase
	endfunction

	function logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Gain times error, floored to Q16.16.
	function longint gain_product(logic [23:0] g, longint err);
		return (longint'(g) * err) >>> 16;
	endfunction

	// Saturated term times the Q0.24 step, floored.
	function longint step_product(longint term, logic [23:0] dt);
		return (longint'(clip32(term)) * longint'(dt)) >>> 24;
	endfunction

	// Advances the observer by one sample; returns 1 when a result is due.
	function bit observer_step(imu_sample_t s, output estimate_t e);
		logic [31:0] age;
		bit          fresh;
		longint      az;
		longint      err;
		longint      za;
		longint      va;
		longint      ba;
		longint      b;
		e = '0;
		if (s.dt == 0 || s.dt > step_limit) return 1'b0;
		age = s.att_time - s.baro_time;
		fresh = s.baro_avail && (s.baro_time != 0) && (age < fresh_window);
		if (!seeded) begin
			if (!fresh) return 1'b0;
			alt_q   = s.baro_alt;
			speed_q = '0;
			bias_q  = '0;
			seeded  = 1'b1;
		end
		az = clip32(longint'($signed(s.accel)) - longint'(bias_q));
		if (fresh) begin
			err = longint'($signed(s.baro_alt)) - longint'(alt_q);
			za = step_product(longint'(speed_q) + gain_product(k_pos, err), s.dt);
			va = step_product(az + gain_product(k_vel, err), s.dt);
			ba = step_product(-gain_product(k_bias, err), s.dt);
			alt_q   = clip32(longint'(alt_q) + za);
			speed_q = clip32(longint'(speed_q) + va);
			b = clip32(longint'(bias_q) + ba);
			if (b > longint'(bias_clamp)) b = longint'(bias_clamp);
			if (b < -longint'(bias_clamp)) b = -longint'(bias_clamp);
			bias_q = b[31:0];
		end else begin
			za = step_product(longint'(speed_q), s.dt);
			va = step_product(az, s.dt);
			alt_q   = clip32(longint'(alt_q) + za);
			speed_q = clip32(longint'(speed_q) + va);
		end
		e.altitude   = alt_q;
		e.speed      = speed_q;
		e.accel_echo = s.accel;
		e.bias       = bias_q;
		e.fresh      = fresh;
		e.dt_echo    = s.dt;
		e.time_echo  = s.att_time;
		return 1'b1;
	endfunction

	function void note_sample(imu_sample_t s);
		estimate_t e;
		if (observer_step(s, e)) expected_q.push_back(e);
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	task report(string msg);
		mismatches++;
		$display("ERROR @%0t:%s", $time, msg);
	endtask

	task check_estimate(estimate_t got);
		estimate_t want;
		string     diffs;
		if (expected_q.size() == 0) begin
			report($sformatf(" result item with none expected, time %h", got.time_echo));
			return;
		end
		want = expected_q.pop_front();
		diffs = "";
		if (got.altitude !== want.altitude)
			diffs = {diffs, $sformatf(" altitude %h/%h", got.altitude, want.altitude)};
		if (got.speed !== want.speed)
			diffs = {diffs, $sformatf(" speed %h/%h", got.speed, want.speed)};
		if (got.accel_echo !== want.accel_echo)
			diffs = {diffs, $sformatf(" accel %h/%h", got.accel_echo, want.accel_echo)};
		if (got.bias !== want.bias)
			diffs = {diffs, $sformatf(" bias %h/%h", got.bias, want.bias)};
		if (got.fresh !== want.fresh)
			diffs = {diffs, $sformatf(" fresh %b/%b", got.fresh, want.fresh)};
		if (got.dt_echo !== want.dt_echo)
			diffs = {diffs, $sformatf(" dt %h/%h", got.dt_echo, want.dt_echo)};
		if (got.time_echo !== want.time_echo)
			diffs = {diffs, $sformatf(" time %h/%h", got.time_echo, want.time_echo)};
		if (diffs != "") report({" result item (got/want):", diffs});
	endtask
endclass

module testbench;

	// Cycles without any handshake before the run is declared hung. The
	// longest legal quiet stretch is the deliberate receiver hold-off.
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	// This covers a dropped item still in flight when the last result has
	// come back.
	localparam int SETTLE_CYCLES   = 30;
	localparam int MAX_GAP         = 17;
	localparam logic signed [31:0] ONE_METER = 32'sd65536;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// [23:0] dt, [55:24] accel_up_in, [87:56] attitude_time_us,
	// [119:88] baro_altitude, [151:120] baro_time_us
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	// [0] baro_available
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// [31:0] altitude, [63:32] vertical_speed, [95:64] accel_up_out,
	// [127:96] accel_bias, [151:128] dt_out, [183:152] time_out_us
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// [0] baro_fresh
	logic                  m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [WORD_W-1:0]     cfg_data;

	altitude_scoreboard sb;

	// Running sample clock and the altitude the simulated barometer follows.
	logic [31:0]        now_us;
	logic signed [31:0] alt_target;
	// Burst flags switch a side between random idling and back-to-back items.
	bit                 send_burst;
	bit                 recv_burst;
	// Set by the stimulus to make the receiver hold off for a long stretch.
	bit                 hold_request;
	int unsigned        stall_count = 0;

	baro_accel_altitude_observer_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic imu_sample_t make_sample(logic [23:0] dt, logic [31:0] accel,
			logic [31:0] att, logic avail, logic [31:0] balt, logic [31:0] bt);
		imu_sample_t s;
		s.dt         = dt;
		s.accel      = accel;
		s.att_time   = att;
		s.baro_avail = avail;
		s.baro_alt   = balt;
		s.baro_time  = bt;
		return s;
	endfunction

	// Offers one item after a random idle gap and waits until the core takes
	// it. The valid flag stays high between back-to-back items.
	task automatic push_sample(imu_sample_t s);
		int unsigned gap;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {s.baro_time, s.baro_alt, s.att_time, s.accel, s.dt};
		s_axis_tuser  <= s.baro_avail;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_sample(s);
	endtask

	// Stops offering items and waits until every expected result has come
	// back and the core has had time to finish any dropped item.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Writes all six registers back to back. Unused upper bits of the gain and
	// bias limit registers carry random junk, which the core must ignore.
	task automatic load_settings(logic [23:0] gp, logic [23:0] gv, logic [23:0] gb,
			logic [30:0] lim, logic [31:0] age, logic [23:0] dtm);
		cfg_write(REG_GAIN_POSITION, {8'($urandom), gp});
		cfg_write(REG_GAIN_VELOCITY, {8'($urandom), gv});
		cfg_write(REG_GAIN_BIAS, {8'($urandom), gb});
		cfg_write(REG_BIAS_LIMIT, {1'($urandom), lim});
		cfg_write(REG_BARO_MAX_AGE, age);
		cfg_write(REG_DT_MAX, {8'd0, dtm});
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed samples on a steadily advancing clock with
	// barometer readings that track a slowly wandering altitude. The rest
	// are bad time steps, stale or untimed readings and full-range values.
	task automatic random_samples(int unsigned count);
		imu_sample_t s;
		int unsigned pick;
		logic [23:0] dt_cap;
		logic [31:0] window;
		logic [31:0] age;
		repeat (count) begin
			dt_cap = sb.step_limit;
			window = sb.fresh_window;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				s.dt = '0;
			else if (pick < 10 && dt_cap != 24'hFF_FFFF)
				s.dt = 24'($urandom_range(32'(dt_cap) + 1, 32'hFF_FFFF));
			else if (pick < 18)
				s.dt = 24'($urandom);
			else if (pick < 60)
				s.dt = 24'($urandom_range(1, (dt_cap > 24'd200000) ? 200000 : dt_cap));
			else
				s.dt = 24'($urandom_range(1, dt_cap));

			now_us = ($urandom_range(0, 99) < 3) ? $urandom
				: now_us + $urandom_range(500, 1500);
			s.att_time = now_us;
			s.accel = ($urandom_range(0, 99) < 15) ? $urandom
				: $urandom_range(0, 2621440) - 32'd1310720;

			alt_target = alt_target + $urandom_range(0, 131072) - 32'd65536;
			s.baro_alt = ($urandom_range(0, 99) < 20) ? $urandom
				: alt_target + $urandom_range(0, 262144) - 32'd131072;

			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// Reading inside the freshness window, unless the window is empty.
				s.baro_avail = 1'b1;
				if (window == 0)
					age = $urandom_range(0, 1000);
				else
					age = $urandom_range(0, (window - 1 > 400000) ? 400000 : window - 1);
				s.baro_time = s.att_time - age;
			end else if (pick < 60) begin
				// Reading at or past the end of the window.
				s.baro_avail = 1'b1;
				age = (window > 32'hFFFF_FC00) ? 32'hFFFF_FFFF
					: window + $urandom_range(0, 1000);
				s.baro_time = s.att_time - age;
			end else if (pick < 70) begin
				s.baro_avail = 1'b1;
				s.baro_time = '0;
			end else begin
				s.baro_avail = 1'b0;
				s.baro_time = $urandom;
			end
			push_sample(s);
		end
	endtask

	// Result side: idles for a random gap before each item, or for a long
	// stretch when asked, then accepts the next result and checks it.
	initial begin : result_sink
		int unsigned gap;
		estimate_t   got;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				gap = HOLD_OFF_CYCLES;
				hold_request = 1'b0;
			end else begin
				gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
			end
			if ($urandom_range(0, 24) == 0) recv_burst = !recv_burst;
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			got.altitude   = m_axis_tdata[31:0];
			got.speed      = m_axis_tdata[63:32];
			got.accel_echo = m_axis_tdata[95:64];
			got.bias       = m_axis_tdata[127:96];
			got.dt_echo    = m_axis_tdata[151:128];
			got.time_echo  = m_axis_tdata[183:152];
			got.fresh      = m_axis_tuser;
			sb.check_estimate(got);
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				stall_count <= 0;
			end else if (stall_count >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				stall_count <= stall_count + 1;
			end
		end
	end

	initial begin : stimulus
		logic [31:0] t;
		sb = new();
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_GAIN_POSITION;
		cfg_data      <= '0;
		arst_n        <= 1'b0;
		now_us = 32'd1_000_000;
		alt_target = 100 * ONE_METER;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		hold_request = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings. Nothing may come out until
		// a fresh reading has been seen on an accepted time step.
		t = now_us;
		// No barometer at all before the observer has started.
		push_sample(make_sample(24'd1000, 32'h0001_0000, t, 1'b0, 32'd0, 32'd0));
		// A fresh reading on a zero time step must not seed the observer.
		push_sample(make_sample(24'd0, 32'h0001_0000, t, 1'b1, 100 * ONE_METER, t - 100));
		// Nor may one on a time step just above the limit.
		push_sample(make_sample(24'(RST_DT_MAX + 1), 32'h0001_0000, t, 1'b1,
			100 * ONE_METER, t - 100));
		// A reading without a timestamp never counts as fresh.
		push_sample(make_sample(24'd1000, 32'h0001_0000, t, 1'b1, 100 * ONE_METER, 32'd0));
		// Age exactly equal to the window is already stale.
		push_sample(make_sample(24'd1000, 32'h0001_0000, t, 1'b1, 100 * ONE_METER,
			t - RST_BARO_MAX_AGE));
		// Age one below the window is fresh and seeds the observer.
		push_sample(make_sample(24'd1000, 32'd642253, t, 1'b1, 100 * ONE_METER,
			t - RST_BARO_MAX_AGE + 1));
		// Largest allowed step with the largest acceleration, open loop.
		push_sample(make_sample(RST_DT_MAX, 32'h7FFF_FFFF, t + 1000, 1'b0, 32'd0, 32'd0));
		// Smallest step with the most negative acceleration.
		push_sample(make_sample(24'd1, 32'h8000_0000, t + 2000, 1'b0, 32'd0, 32'd0));
		// Huge positive then negative altitude errors drive the bias into its clamp.
		push_sample(make_sample(RST_DT_MAX, 32'd0, t + 3000, 1'b1, 32'h7FFF_FFFF, t + 2990));
		push_sample(make_sample(RST_DT_MAX, 32'd0, t + 4000, 1'b1, 32'h8000_0000, t + 3990));
		push_sample(make_sample(RST_DT_MAX, 32'h8000_0000, t + 5000, 1'b1, 32'h8000_0000,
			t + 4990));
		// Timestamps wrapping between the reading and the sample.
		push_sample(make_sample(24'd16777, 32'h0000_8000, 32'd5, 1'b1, 50 * ONE_METER,
			32'hFFFF_FFF0));
		// All-ones step is dropped; all-ones barometer fields are ignored.
		push_sample(make_sample(24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		push_sample(make_sample(24'd5000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// A few ordinary corrections to pull the estimates back in range.
		push_sample(make_sample(24'd16777, 32'd642253, 32'd1000, 1'b1, 100 * ONE_METER, 32'd990));
		push_sample(make_sample(24'd16777, 32'd642253, 32'd2000, 1'b1, 101 * ONE_METER, 32'd1990));
		push_sample(make_sample(24'd16777, 32'd0, 32'd3000, 1'b0, 32'd0, 32'd0));
		now_us = 32'd10_000;
		settle();

		// Reset settings, with the receiver held off once while the sender
		// keeps items coming back to back.
		hold_request = 1'b1;
		send_burst = 1'b1;
		random_samples(120);
		settle();

		// Every register at its maximum.
		load_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF,
			32'hFFFF_FFFF, 24'hFF_FFFF);
		random_samples(100);
		settle();

		// Zero gains and a zero bias clamp, with the shortest step limit.
		load_settings(24'd0, 24'd0, 24'd0, 31'd0, 32'd5000, 24'd1);
		random_samples(80);
		settle();

		// Random gains and step limit, and a zero window so no reading is fresh.
		load_settings(24'($urandom), 24'($urandom), 24'($urandom), 31'($urandom), 32'd0,
			24'($urandom_range(1, 24'hFF_FFFF)));
		random_samples(100);
		settle();

		// Nominal gains with a tight bias clamp and a short window.
		load_settings(RST_GAIN_POSITION, RST_GAIN_VELOCITY, RST_GAIN_BIAS, 31'd4096,
			32'd1000, 24'h3F_FFFF);
		random_samples(100);
		settle();

		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
